/* rtl/core/tht_pkg.sv */
`default_nettype none

package tht_pkg;

    localparam int ID_W        = 5;
    localparam int COORD_W     = 16;
    localparam int REGIONS_DEF = 32;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        REQ_TOUCH = 2'd0,
        REQ_REG   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_IDLE    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_HOLD    = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_TOUCH,
        OP_SCAN,
        OP_REG,
        OP_CLEAR,
        OP_QUERY
    } t_op;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_rect;

    // one classified request waiting for the back end
    typedef struct packed {
        t_op             op;
        t_kind           kind;
        logic [ID_W-1:0] id;
        t_rect           rect;
    } t_qent;

    typedef struct packed {
        t_kind           kind;
        logic            hit;
        logic [ID_W-1:0] hit_region;
        logic            released_flag;
        logic            error;
    } t_res;

    // inclusive bounds, 17-bit far edges
    function automatic logic rect_contains(input t_rect r,
                                           input logic [COORD_W-1:0] px,
                                           input logic [COORD_W-1:0] py);
        logic [COORD_W:0] x1;
        logic [COORD_W:0] y1;
        x1 = {1'b0, r.x} + {1'b0, r.w};
        y1 = {1'b0, r.y} + {1'b0, r.h};
        return (px >= r.x) && (py >= r.y) &&
               ({1'b0, px} <= x1) && ({1'b0, py} <= y1);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tht_front.sv */
`default_nettype none

module tht_front import tht_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire [1:0]           i_req_type,
    input  wire [ID_W-1:0]      i_region_id,
    input  wire [COORD_W-1:0]   i_pos_x,
    input  wire [COORD_W-1:0]   i_pos_y,
    input  wire [COORD_W-1:0]   i_size_w,
    input  wire [COORD_W-1:0]   i_size_h,
    input  wire                 i_touch_up,
    input  wire                 i_touch_held,
    output t_qent               o_head,
    output logic                o_head_vld,
    input  wire                 i_pop
);

    t_qent              r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    t_qent              ent;
    t_kind              kind;
    logic               push;
    logic               pop;

    always_comb begin
        if (i_touch_held && i_touch_up) begin
            kind = KIND_RELEASE;
        end else if (i_touch_held) begin
            kind = KIND_HOLD;
        end else if (!i_touch_up) begin
            kind = KIND_PRESS;
        end else begin
            kind = KIND_IDLE;
        end

        ent.kind   = KIND_IDLE;
        ent.id     = i_region_id;
        ent.rect.x = i_pos_x;
        ent.rect.y = i_pos_y;
        ent.rect.w = i_size_w;
        ent.rect.h = i_size_h;
        case (t_req'(i_req_type))
            REQ_TOUCH: begin
                ent.kind = kind;
                ent.op   = (kind == KIND_PRESS || kind == KIND_RELEASE) ? OP_SCAN
                                                                         : OP_TOUCH;
            end
            REQ_REG:   ent.op = OP_REG;
            REQ_CLEAR: ent.op = OP_CLEAR;
            REQ_QUERY: ent.op = OP_QUERY;
            default:   ent.op = OP_QUERY;
        endcase
    end

    assign busy       = (r_count == QCNT_W'(QDEPTH));
    assign push       = start && !busy;
    assign pop        = i_pop && o_head_vld;
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= ent;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tht_back.sv */
`default_nettype none

module tht_back import tht_pkg::*; #(
    parameter int REGIONS = REGIONS_DEF
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_qent  i_head,
    input  wire    i_head_vld,
    output logic   o_pop,
    output logic   o_valid,
    output t_res   o_res
);

    localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    t_rect               r_mem [REGIONS];
    t_rect               r_rd_data;
    logic [REGIONS-1:0]  r_slot_valid;
    logic [REGIONS-1:0]  r_slot_rel;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    t_qent               r_cur, n_cur;
    logic                r_valid, n_valid;
    t_res                r_res, n_res;

    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       slot;
    logic                in_range;
    logic                slot_live;
    logic                scan_hit;
    logic                scan_last;
    logic                do_reg;
    logic                do_clr;
    logic                do_rel;
    logic                rel_val;

    assign slot      = IW'(i_head.id);
    assign in_range  = 32'(i_head.id) < REGIONS;
    assign slot_live = in_range && r_slot_valid[slot];
    assign scan_hit  = r_slot_valid[r_idx] &&
                       rect_contains(r_rd_data, r_cur.rect.x, r_cur.rect.y);
    assign scan_last = (r_idx == IW'(REGIONS - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cur   = r_cur;
        n_valid = 1'b0;
        n_res   = '0;
        o_pop   = 1'b0;
        rd_addr = '0;
        do_reg  = 1'b0;
        do_clr  = 1'b0;
        do_rel  = 1'b0;
        rel_val = (r_cur.kind == KIND_RELEASE);

        case (r_state)
            S_IDLE: begin
                if (i_head_vld) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        OP_SCAN: begin
                            // read of slot 0 goes out now, compared next cycle
                            n_cur   = i_head;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        OP_TOUCH: begin
                            n_valid    = 1'b1;
                            n_res.kind = i_head.kind;
                        end
                        OP_REG: begin
                            n_valid = 1'b1;
                            do_reg  = in_range;
                        end
                        OP_CLEAR: begin
                            n_valid     = 1'b1;
                            do_clr      = slot_live;
                            n_res.error = !slot_live;
                        end
                        OP_QUERY: begin
                            n_valid             = 1'b1;
                            n_res.error         = !slot_live;
                            n_res.released_flag = slot_live && r_slot_rel[slot];
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                rd_addr    = r_idx + IW'(1);
                n_idx      = r_idx + IW'(1);
                n_res.kind = r_cur.kind;
                if (scan_hit || scan_last) begin
                    n_valid          = 1'b1;
                    n_res.hit        = scan_hit;
                    n_res.hit_region = scan_hit ? ID_W'(r_idx) : '0;
                    do_rel           = scan_hit;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cur <= n_cur;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_slot_rel   <= '0;
        end else begin
            if (do_reg) begin
                r_slot_valid[slot] <= 1'b1;
                r_slot_rel[slot]   <= 1'b0;
            end
            if (do_clr) begin
                r_slot_valid[slot] <= 1'b0;
            end
            if (do_rel) begin
                r_slot_rel[r_idx] <= rel_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_reg) begin
            r_mem[slot] <= i_head.rect;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_hit_needs_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.hit |-> r_res.kind == KIND_PRESS || r_res.kind == KIND_RELEASE)
        else $error("hit reported for a request that does not search");

    a_hit_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_res.hit && r_res.error))
        else $error("hit and error in the same result");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && (scan_hit || scan_last) |=> r_valid && r_state == S_IDLE)
        else $error("finished search gave no result");

    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_vld && r_state == S_IDLE)
        else $error("queue popped while empty or mid search");

    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && scan_hit |=> r_slot_valid[$past(r_idx)])
        else $error("hit on an empty slot");

endmodule

`default_nettype wire

/* rtl/core/touch_region_hit_tester_core.sv */
`default_nettype none

// touch region hit tester
// one request channel: the request fields are taken at a rising edge where
// start is high and busy is low. busy rises only when the two-entry request
// queue is full, so up to two requests can be taken while a search runs.
// one result per request on the o_ fields, marked by o_valid for exactly one
// cycle; the receiver cannot hold results off and none is needed, since the
// back end never waits on the output.
// register, clear, query, hold and idle move pass through the queue and the
// result register to o_valid; the back end takes one such request per cycle
// while no search runs. press and release walk the rectangle memory one
// slot per cycle from slot 0 and stop at the first hit, else at the last slot.
// the search rate is set by the single read port of the rectangle memory.
// reset (synchronous, active low) empties the queue and drops every valid
// mark and released flag at once; no clearing pass, the block takes a request
// as soon as reset is released.
module touch_region_hit_tester_core import tht_pkg::*; #(
    parameter int REGIONS = REGIONS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire [1:0]           i_req_type,
    input  wire [ID_W-1:0]      i_region_id,
    input  wire [COORD_W-1:0]   i_pos_x,
    input  wire [COORD_W-1:0]   i_pos_y,
    input  wire [COORD_W-1:0]   i_size_w,
    input  wire [COORD_W-1:0]   i_size_h,
    input  wire                 i_touch_up,
    input  wire                 i_touch_held,
    output logic                o_valid,
    output logic [1:0]          o_touch_kind,
    output logic                o_hit,
    output logic [ID_W-1:0]     o_hit_region,
    output logic                o_released_flag,
    output logic                o_error
);

    t_qent  head;
    logic   head_vld;
    logic   pop;
    t_res   res;

    tht_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_region_id  (i_region_id),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_size_w     (i_size_w),
        .i_size_h     (i_size_h),
        .i_touch_up   (i_touch_up),
        .i_touch_held (i_touch_held),
        .o_head       (head),
        .o_head_vld   (head_vld),
        .i_pop        (pop)
    );

    tht_back #(
        .REGIONS (REGIONS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_head_vld (head_vld),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_res      (res)
    );

    assign o_touch_kind    = res.kind;
    assign o_hit           = res.hit;
    assign o_hit_region    = res.hit_region;
    assign o_released_flag = res.released_flag;
    assign o_error         = res.error;

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench import tht_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REGIONS  = REGIONS_DEF;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        t_req                req;
        logic [ID_W-1:0]     id;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  w;
        logic [COORD_W-1:0]  h;
        logic                up;
        logic                held;
    } t_request;

    // mirror of the region table plus the responses still owed by the block
    class region_table;
        bit    slot_used[NUM_REGIONS];
        t_rect slot_rect[NUM_REGIONS];
        bit    slot_released[NUM_REGIONS];
        t_res  owed_responses[$];
        int    failures;

        function bit covers(int s, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
            logic [COORD_W:0] x_end;
            logic [COORD_W:0] y_end;
            x_end = {1'b0, slot_rect[s].x} + {1'b0, slot_rect[s].w};
            y_end = {1'b0, slot_rect[s].y} + {1'b0, slot_rect[s].h};
            return px >= slot_rect[s].x && py >= slot_rect[s].y &&
                   {1'b0, px} <= x_end && {1'b0, py} <= y_end;
        endfunction

        function void note_request(t_request rq);
            t_res r;
            r = '{kind: KIND_IDLE, hit: 1'b0, hit_region: '0,
                  released_flag: 1'b0, error: 1'b0};
            case (rq.req)
                REQ_TOUCH: begin
                    if (rq.held && rq.up) r.kind = KIND_RELEASE;
                    else if (rq.held) r.kind = KIND_HOLD;
                    else if (!rq.up) r.kind = KIND_PRESS;
                    // only press and release search, first match wins
                    if (r.kind == KIND_PRESS || r.kind == KIND_RELEASE) begin
                        for (int s = 0; s < NUM_REGIONS; s++) begin
                            if (slot_used[s] && covers(s, rq.x, rq.y)) begin
                                r.hit = 1'b1;
                                r.hit_region = ID_W'(s);
                                slot_released[s] = (r.kind == KIND_RELEASE);
                                break;
                            end
                        end
                    end
                end
                REQ_REG: begin
                    slot_used[rq.id] = 1'b1;
                    slot_rect[rq.id] = '{x: rq.x, y: rq.y, w: rq.w, h: rq.h};
                    slot_released[rq.id] = 1'b0;
                end
                REQ_CLEAR: begin
                    if (slot_used[rq.id]) slot_used[rq.id] = 1'b0;
                    else r.error = 1'b1;
                end
                default: begin
                    if (slot_used[rq.id]) r.released_flag = slot_released[rq.id];
                    else r.error = 1'b1;
                end
            endcase
            owed_responses.push_back(r);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (owed_responses.size() == 0) begin
                $error("response word with none outstanding: touch_kind %0d hit %0d",
                       got.kind, got.hit);
                failures++;
                return;
            end
            want = owed_responses.pop_front();
            if (got.kind !== want.kind) begin
                $error("touch_kind: expected %0d, got %0d", want.kind, got.kind);
                failures++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                failures++;
            end
            if (got.hit_region !== want.hit_region) begin
                $error("hit_region: expected %0d, got %0d", want.hit_region, got.hit_region);
                failures++;
            end
            if (got.released_flag !== want.released_flag) begin
                $error("released_flag: expected %0d, got %0d",
                       want.released_flag, got.released_flag);
                failures++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0d, got %0d", want.error, got.error);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_req_type;
    logic [ID_W-1:0]     i_region_id;
    logic [COORD_W-1:0]  i_pos_x;
    logic [COORD_W-1:0]  i_pos_y;
    logic [COORD_W-1:0]  i_size_w;
    logic [COORD_W-1:0]  i_size_h;
    logic                i_touch_up;
    logic                i_touch_held;
    logic                o_valid;
    logic [1:0]          o_touch_kind;
    logic                o_hit;
    logic [ID_W-1:0]     o_hit_region;
    logic                o_released_flag;
    logic                o_error;

    region_table sb = new;
    int          cycles = 0;

    touch_region_hit_tester_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_region_id     (i_region_id),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_size_w        (i_size_w),
        .i_size_h        (i_size_h),
        .i_touch_up      (i_touch_up),
        .i_touch_held    (i_touch_held),
        .o_valid         (o_valid),
        .o_touch_kind    (o_touch_kind),
        .o_hit           (o_hit),
        .o_hit_region    (o_hit_region),
        .o_released_flag (o_released_flag),
        .o_error         (o_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_result('{kind: t_kind'(o_touch_kind), hit: o_hit,
                              hit_region: o_hit_region, released_flag: o_released_flag,
                              error: o_error});
        end
    end

    function automatic int burst_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
    endfunction

    // coordinate at or just outside an edge of [lo, lo+len] or anywhere inside it, clipped to 16 bits
    function automatic logic [COORD_W-1:0] coord_near(logic [COORD_W-1:0] lo,
                                                    logic [COORD_W-1:0] len);
        int span;
        span = (int'(lo) + int'(len) > 65535) ? 65535 - int'(lo) : int'(len);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return COORD_W'(int'(lo) + span);
            2: return COORD_W'(int'(lo) + span + 1);
            3: return COORD_W'(int'(lo) - 1);
            default: return COORD_W'(int'(lo) + $urandom_range(0, span));
        endcase
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int       roll;
        int       s;
        int       slot;
        rq = '{req: REQ_TOUCH, id: ID_W'($urandom), x: COORD_W'($urandom),
               y: COORD_W'($urandom), w: COORD_W'($urandom), h: COORD_W'($urandom),
               up: 1'($urandom), held: 1'($urandom)};
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            rq.req = REQ_REG;
            // mostly small rectangles in a crowded corner so they overlap
            if ($urandom_range(0, 3) != 0) begin
                rq.x = COORD_W'($urandom_range(0, 2047));
                rq.y = COORD_W'($urandom_range(0, 2047));
                rq.w = COORD_W'($urandom_range(0, 400));
                rq.h = COORD_W'($urandom_range(0, 400));
            end
        end else if (roll < 70) begin
            slot = -1;
            s = $urandom_range(0, NUM_REGIONS - 1);
            for (int k = 0; k < NUM_REGIONS; k++) begin
                if (slot < 0 && sb.slot_used[(s + k) % NUM_REGIONS]) slot = (s + k) % NUM_REGIONS;
            end
            if (slot >= 0 && $urandom_range(0, 3) != 0) begin
                rq.x = coord_near(sb.slot_rect[slot].x, sb.slot_rect[slot].w);
                rq.y = coord_near(sb.slot_rect[slot].y, sb.slot_rect[slot].h);
            end else if ($urandom_range(0, 1) == 0) begin
                rq.x = COORD_W'($urandom_range(0, 2047));
                rq.y = COORD_W'($urandom_range(0, 2047));
            end
        end else if (roll < 85) begin
            rq.req = REQ_CLEAR;
        end else begin
            rq.req = REQ_QUERY;
        end
        return rq;
    endfunction

    task automatic drive_request(input t_request rq, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
            i_req_type = 2'($urandom);
            i_region_id = ID_W'($urandom);
            i_pos_x = COORD_W'($urandom);
            i_pos_y = COORD_W'($urandom);
        end
        @(negedge i_clk);
        start = 1'b1;
        i_req_type = rq.req;
        i_region_id = rq.id;
        i_pos_x = rq.x;
        i_pos_y = rq.y;
        i_size_w = rq.w;
        i_size_h = rq.h;
        i_touch_up = rq.up;
        i_touch_held = rq.held;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(rq);
    endtask

    task automatic slot_request(input t_req req, input int id, input int x = 0,
                                input int y = 0, input int w = 0, input int h = 0);
        drive_request('{req: req, id: ID_W'(id), x: COORD_W'(x), y: COORD_W'(y),
                        w: COORD_W'(w), h: COORD_W'(h), up: 1'b0, held: 1'b0},
                      burst_gap());
    endtask

    task automatic touch(input int x, input int y, input bit up, input bit held);
        drive_request('{req: REQ_TOUCH, id: ID_W'($urandom), x: COORD_W'(x),
                        y: COORD_W'(y), w: COORD_W'($urandom), h: COORD_W'($urandom),
                        up: up, held: held}, burst_gap());
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = REQ_TOUCH;
        i_region_id = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_size_w = '0;
        i_size_h = '0;
        i_touch_up = 1'b0;
        i_touch_held = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table
        slot_request(REQ_QUERY, 0);
        slot_request(REQ_CLEAR, 31);
        touch(0, 0, 1'b0, 1'b0);
        // overlapping rectangles, a single point, far edges past 16 bits, a full-width line
        slot_request(REQ_REG, 5, 100, 100, 50, 50);
        slot_request(REQ_REG, 2, 120, 120, 0, 0);
        slot_request(REQ_REG, 31, 65535, 65535, 65535, 65535);
        slot_request(REQ_REG, 0, 0, 0, 65535, 0);
        touch(120, 120, 1'b0, 1'b0);
        touch(150, 150, 1'b1, 1'b1);
        slot_request(REQ_QUERY, 5);
        touch(151, 150, 1'b1, 1'b1);
        touch(120, 120, 1'b0, 1'b1);
        touch(120, 120, 1'b1, 1'b0);
        touch(65535, 65535, 1'b1, 1'b1);
        slot_request(REQ_QUERY, 31);
        touch(65535, 0, 1'b0, 1'b0);
        // overwrite drops the released flag
        slot_request(REQ_REG, 5, 0, 0, 0, 0);
        slot_request(REQ_QUERY, 5);
        slot_request(REQ_CLEAR, 2);
        slot_request(REQ_QUERY, 2);
        slot_request(REQ_CLEAR, 2);
        touch(0, 0, 1'b1, 1'b1);
        slot_request(REQ_QUERY, 0);
        slot_request(REQ_REG, 2, 99, 99, 0, 0);
        slot_request(REQ_QUERY, 2);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // alternate stretches with and without idling, none at the tail
            if (n < RANDOM_ITEMS - QUIET_TAIL && (n / 64) % 2 == 0)
                drive_request(random_request(), burst_gap());
            else
                drive_request(random_request(), 0);
        end
        @(negedge i_clk);
        start = 1'b0;

        while (sb.owed_responses.size() != 0) @(posedge i_clk);
        repeat (NUM_REGIONS + 8) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
